FILE: rtl/assert_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AST_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/fbhp_pkg.sv
// Types, constants and decode functions for the firmware block header parser.
`timescale 1ns / 1ps

package fbhp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hDB;
    localparam logic [7:0] SYNC_SECOND = 8'hD7;

    localparam logic [3:0] HLEN_SHORT = 4'd4;
    localparam logic [3:0] HLEN_MID   = 4'd8;
    localparam logic [3:0] HLEN_LONG  = 4'd12;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam int TDATA_W = 112;

    typedef enum logic [1:0] {
        KIND_HEADER     = 2'd0,
        KIND_BAD_SYNC   = 2'd1,
        KIND_DONE_OK    = 2'd2,
        KIND_DONE_TRUNC = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [31:0]        block_offset;
        logic [7:0]         opcode;
        logic [3:0]         count_n;
        logic [3:0]         header_length;
        logic [31:0]        payload_length;
        logic signed [31:0] word_sum;
    } t_result;

    // Results caused by one byte: up to two, the second always a done report.
    typedef struct packed {
        logic [1:0] num;
        t_result    res_a;
        t_result    res_b;
    } t_group;

    function automatic logic [3:0] header_len_of(input logic [7:0] op);
        logic [3:0] hlen;
        case (op)
            8'd0, 8'd1, 8'd4, 8'd5: hlen = HLEN_MID;
            8'd2, 8'd3:             hlen = HLEN_LONG;
            default:                hlen = HLEN_SHORT;
        endcase
        return hlen;
    endfunction

    function automatic logic [31:0] payload_of(input logic [7:0] op, input logic [3:0] cnt,
                                               input logic [31:0] word);
        logic [31:0] plen;
        case (op)
            8'd0, 8'd2: plen = word;
            8'd6, 8'd8: plen = {26'd0, cnt, 2'b00};
            default:    plen = 32'd0;
        endcase
        return plen;
    endfunction

endpackage

FILE: rtl/fbhp_parser.sv
// Header parser state and per-byte decode, with the running word sum.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fbhp_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output logic            o_group_valid,
    output fbhp_pkg::t_group o_group
);
    import fbhp_pkg::*;

    logic [3:0]  r_header_index, n_header_index;
    logic [31:0] r_cur_offset,   n_cur_offset;
    logic [31:0] r_block_start,  n_block_start;
    logic [7:0]  r_opcode,       n_opcode;
    logic [3:0]  r_count,        n_count;
    logic [31:0] r_length_word,  n_length_word;
    logic [31:0] r_payload_left, n_payload_left;
    logic        r_error,        n_error;
    logic [31:0] r_sum,          n_sum;
    logic [23:0] r_word_asm,     n_word_asm;

    logic [1:0]  lane;
    logic [31:0] word_v;
    logic [7:0]  op_v;
    logic [31:0] lw_v;
    logic [3:0]  hlen_v;
    logic [31:0] plen_v;
    t_group      n_group;
    t_result     done_res;

    always_comb begin
        n_header_index = r_header_index;
        n_cur_offset   = r_cur_offset;
        n_block_start  = r_block_start;
        n_opcode       = r_opcode;
        n_count        = r_count;
        n_length_word  = r_length_word;
        n_payload_left = r_payload_left;
        n_error        = r_error;
        n_sum          = r_sum;
        n_word_asm     = r_word_asm;
        n_group        = '0;
        done_res       = '0;
        op_v           = r_opcode;
        lw_v           = r_length_word;
        hlen_v         = header_len_of(r_opcode);
        plen_v         = '0;
        lane           = r_cur_offset[1:0];
        word_v         = {8'd0, r_word_asm} | ({24'd0, i_byte} << {lane, 3'b000});

        if (i_valid) begin
            if (lane == 2'd3 || i_last) begin
                n_sum      = r_sum + word_v;
                n_word_asm = '0;
            end else begin
                n_word_asm = word_v[23:0];
            end

            if (r_error) begin
                // ignore bytes until the end of the image
            end else if (r_payload_left != 32'd0) begin
                n_payload_left = r_payload_left - 32'd1;
            end else begin
                case (r_header_index)
                    4'd0: begin
                        n_block_start  = r_cur_offset;
                        n_opcode       = i_byte;
                        n_header_index = 4'd1;
                    end
                    4'd1: begin
                        if (r_opcode != SYNC_FIRST || i_byte != SYNC_SECOND) begin
                            n_group.num                = 2'd1;
                            n_group.res_a.kind         = KIND_BAD_SYNC;
                            n_group.res_a.block_offset = r_block_start;
                            n_error                    = 1'b1;
                            n_header_index             = 4'd0;
                        end else begin
                            n_header_index = 4'd2;
                        end
                    end
                    4'd2: begin
                        n_count        = i_byte[3:0];
                        n_header_index = 4'd3;
                    end
                    default: begin
                        op_v = (r_header_index == 4'd3) ? i_byte : r_opcode;
                        if (r_header_index == 4'd3) begin
                            lw_v = '0;
                        end else if (r_header_index <= 4'd7) begin
                            lw_v = r_length_word
                                 | ({24'd0, i_byte} << {r_header_index[1:0], 3'b000});
                        end else begin
                            lw_v = r_length_word;
                        end
                        hlen_v        = header_len_of(op_v);
                        n_opcode      = op_v;
                        n_length_word = lw_v;
                        if ({1'b0, r_header_index} + 5'd1 >= {1'b0, hlen_v}) begin
                            plen_v                       = payload_of(op_v, r_count, lw_v);
                            n_group.num                  = 2'd1;
                            n_group.res_a.kind           = KIND_HEADER;
                            n_group.res_a.block_offset   = r_block_start;
                            n_group.res_a.opcode         = op_v;
                            n_group.res_a.count_n        = r_count;
                            n_group.res_a.header_length  = hlen_v;
                            n_group.res_a.payload_length = plen_v;
                            n_payload_left               = plen_v;
                            n_header_index               = 4'd0;
                        end else begin
                            n_header_index = r_header_index + 4'd1;
                        end
                    end
                endcase
            end

            n_cur_offset = r_cur_offset + 32'd1;

            if (i_last) begin
                if (!n_error && n_header_index != 4'd0) begin
                    done_res.kind         = KIND_DONE_TRUNC;
                    done_res.block_offset = n_block_start;
                end else begin
                    done_res.kind = KIND_DONE_OK;
                end
                done_res.word_sum = $signed(n_sum);
                if (n_group.num == 2'd0) begin
                    n_group.res_a = done_res;
                end else begin
                    n_group.res_b = done_res;
                end
                n_group.num = n_group.num + 2'd1;

                // start a fresh image at offset zero
                n_header_index = '0;
                n_cur_offset   = '0;
                n_block_start  = '0;
                n_opcode       = '0;
                n_count        = '0;
                n_length_word  = '0;
                n_payload_left = '0;
                n_error        = 1'b0;
                n_sum          = '0;
                n_word_asm     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_index <= '0;
            r_cur_offset   <= '0;
            r_block_start  <= '0;
            r_opcode       <= '0;
            r_count        <= '0;
            r_length_word  <= '0;
            r_payload_left <= '0;
            r_error        <= 1'b0;
            r_sum          <= '0;
            r_word_asm     <= '0;
        end else begin
            r_header_index <= n_header_index;
            r_cur_offset   <= n_cur_offset;
            r_block_start  <= n_block_start;
            r_opcode       <= n_opcode;
            r_count        <= n_count;
            r_length_word  <= n_length_word;
            r_payload_left <= n_payload_left;
            r_error        <= n_error;
            r_sum          <= n_sum;
            r_word_asm     <= n_word_asm;
        end
    end

    assign o_group_valid = (n_group.num != 2'd0);
    assign o_group       = n_group;

    `AST_IMPLIES(a_index_in_range, 1'b1, r_header_index < HLEN_LONG)
    `AST_IMPLIES(a_error_is_quiet, r_error, r_header_index == 4'd0 && r_payload_left == 32'd0)
    `AST_NEXT(a_fresh_after_last, i_valid && i_last, r_cur_offset == 32'd0 && r_sum == 32'd0)

endmodule

FILE: rtl/fbhp_out_queue.sv
// Result queue: one entry per byte's result group, drained one result per transfer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fbhp_out_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_wr_en,
    input  fbhp_pkg::t_group        i_wr_group,
    output logic [fbhp_pkg::QCNT_W-1:0] o_count,
    input  logic                    i_ready,
    output logic                    o_valid,
    output fbhp_pkg::t_result       o_result,
    output logic                    o_last
);
    import fbhp_pkg::*;

    t_group             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count,  n_count;
    logic               r_sub,    n_sub;
    t_group             head;
    logic               xfer;
    logic               pop;

    assign head     = r_mem[r_rd_ptr];
    assign o_valid  = (r_count != '0);
    assign o_last   = (head.num != 2'd2) || r_sub;
    assign o_result = r_sub ? head.res_b : head.res_a;
    assign xfer     = o_valid && i_ready;
    assign pop      = xfer && o_last;
    assign o_count  = r_count;

    always_comb begin
        n_wr_ptr = i_wr_en ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count + QCNT_W'(i_wr_en) - QCNT_W'(pop);
        // advance to the second result of a pair, back to the first on pop
        n_sub    = xfer ? !o_last : r_sub;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_sub    <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            r_sub    <= n_sub;
        end
    end

    `AST_IMPLIES(a_no_write_when_full, i_wr_en, r_count != QCNT_W'(QUEUE_DEPTH))
    `AST_IMPLIES(a_sub_only_on_pair, r_sub, o_valid && head.num == 2'd2)

endmodule

FILE: rtl/firmware_block_header_parser_unit.sv
// Top level of the firmware block header parser: input register, parser and result queue.
`timescale 1ns / 1ps

// Takes a firmware image one byte per transfer and accepts a byte in every cycle while the
// result queue has room; a byte's results pass the input register and are written to the
// result queue before they reach the master side. Most bytes give no result, a completed
// header gives one, and a bad sync word gives one too; the last byte of the image adds a
// done report carrying the 32-bit word sum, which also flags a header cut short by the end
// of the image and leaves after any result that shares its byte. The four-entry result
// queue sets how far the master side may stall before the slave side is held off. After the
// last byte every offset restarts from zero for the next image.
module firmware_block_header_parser_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // data_byte
    input  logic                          s_axis_tlast,  // last_of_file
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // block_offset[31:0], opcode[39:32], count_n[43:40], header_length[47:44],
    // payload_length[79:48], word_sum[111:80]
    output logic [fbhp_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]                    m_axis_tuser,  // kind
    output logic                          m_axis_tlast   // last_result
);
    import fbhp_pkg::*;

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic              accept;
    logic              group_valid;
    t_group            group;
    logic [QCNT_W-1:0] q_count;
    t_result           result;

    // hold off unless the queue can take the byte in flight and this one
    assign s_axis_tready = ({1'b0, q_count} + {{QCNT_W{1'b0}}, r_in_valid})
                           < (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    fbhp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_in_valid),
        .i_byte        (r_in_byte),
        .i_last        (r_in_last),
        .o_group_valid (group_valid),
        .o_group       (group)
    );

    fbhp_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (group_valid),
        .i_wr_group (group),
        .o_count    (q_count),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_result   (result),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {result.word_sum, result.payload_length, result.header_length,
                           result.count_n, result.opcode, result.block_offset};
    assign m_axis_tuser = result.kind;

endmodule
